FILE: rtl/key_matrix_debounce_hold_events_assert.svh
// ----------------------------------------------------------------------------
// key matrix debounce assertion macros
// concurrent assertion helpers, clocked on clk and disabled in reset
// ----------------------------------------------------------------------------
`ifndef KEY_MATRIX_DEBOUNCE_HOLD_EVENTS_ASSERT_SVH
`define KEY_MATRIX_DEBOUNCE_HOLD_EVENTS_ASSERT_SVH

`ifndef SYNTHESIS

`define KMDH_ASSERT_ALWAYS(label, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("kmdh assertion failed");

`define KMDH_ASSERT_IMPLY(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("kmdh assertion failed");

`define KMDH_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("kmdh assertion failed");

`else

`define KMDH_ASSERT_ALWAYS(label, cond)
`define KMDH_ASSERT_IMPLY(label, ante, cons)
`define KMDH_ASSERT_NEXT(label, ante, cons)

`endif

`endif

FILE: rtl/kmdh_pkg.sv
// ----------------------------------------------------------------------------
// kmdh_pkg
// shared types and constants of the key matrix debounce block
// ----------------------------------------------------------------------------
package kmdh_pkg;

  localparam int KEY_COUNT = 16;
  localparam int KEY_W     = 4;
  localparam int TIME_W    = 32;
  localparam int MS_W      = 16;

  localparam int Q_DEPTH   = 4;
  localparam int Q_PTR_W   = 2;
  localparam int Q_CNT_W   = 3;

  localparam logic [15:0] DEBOUNCE_RESET = 16'd20;
  localparam logic [15:0] HOLD_RESET     = 16'd500;

  typedef enum logic [1:0] {
    KIND_PRESS   = 2'd0,
    KIND_RELEASE = 2'd1,
    KIND_HOLD    = 2'd2
  } kmdh_kind_t;

  typedef enum logic {
    REG_DEBOUNCE = 1'b0,
    REG_HOLD     = 1'b1
  } kmdh_reg_t;

  // one record per sample that produced at least one event
  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic             chg_valid;  // press or release present
    logic             chg_press;  // 1 press, 0 release
    logic             hold;       // hold event follows
  } kmdh_rec_t;

endpackage

FILE: rtl/kmdh_front.sv
// ----------------------------------------------------------------------------
// kmdh_front
// per-key state and classification of each accepted sample into an event record
// ----------------------------------------------------------------------------
`include "key_matrix_debounce_hold_events_assert.svh"

module kmdh_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          accept,
  input  logic [kmdh_pkg::KEY_W-1:0]    key_index,
  input  logic                          raw_pressed,
  input  logic [kmdh_pkg::TIME_W-1:0]   now_ms,
  input  logic [kmdh_pkg::MS_W-1:0]     debounce_ms,
  input  logic [kmdh_pkg::MS_W-1:0]     hold_ms,
  output logic                          rec_push,
  output kmdh_pkg::kmdh_rec_t           rec
);

  logic [kmdh_pkg::KEY_COUNT-1:0] raw_level;
  logic [kmdh_pkg::KEY_COUNT-1:0] debounced_level;
  logic [kmdh_pkg::KEY_COUNT-1:0] hold_reported;
  logic [kmdh_pkg::TIME_W-1:0]    raw_change_time [kmdh_pkg::KEY_COUNT];
  logic [kmdh_pkg::TIME_W-1:0]    press_time      [kmdh_pkg::KEY_COUNT];

  logic                        key_ok;
  logic                        raw_changed;
  logic [kmdh_pkg::TIME_W-1:0] change_time_next;
  logic [kmdh_pkg::TIME_W-1:0] db_elapsed;
  logic                        chg;
  logic                        deb_next;
  logic                        pressed_now;
  logic [kmdh_pkg::TIME_W-1:0] press_time_next;
  logic                        hold_rep_next;
  logic [kmdh_pkg::TIME_W-1:0] hold_elapsed;
  logic                        hold_evt;
  logic                        upd;

  always_comb begin
    key_ok           = ({{(32-kmdh_pkg::KEY_W){1'b0}}, key_index} < 32'(kmdh_pkg::KEY_COUNT));
    raw_changed      = raw_pressed != raw_level[key_index];
    change_time_next = raw_changed ? now_ms : raw_change_time[key_index];
    db_elapsed       = now_ms - change_time_next;
    chg              = (raw_pressed != debounced_level[key_index]) &&
                       (db_elapsed >= {{(kmdh_pkg::TIME_W-kmdh_pkg::MS_W){1'b0}}, debounce_ms});
    deb_next         = chg ? raw_pressed : debounced_level[key_index];
    pressed_now      = chg && raw_pressed;
    press_time_next  = pressed_now ? now_ms : press_time[key_index];
    hold_rep_next    = pressed_now ? 1'b0 : hold_reported[key_index];
    hold_elapsed     = now_ms - press_time[key_index];
    // a press in this sample starts the hold time at zero
    if (pressed_now) begin
      hold_evt = hold_ms == '0;
    end else begin
      hold_evt = deb_next && !hold_reported[key_index] &&
                 (hold_elapsed >= {{(kmdh_pkg::TIME_W-kmdh_pkg::MS_W){1'b0}}, hold_ms});
    end
    upd              = accept && key_ok;

    rec_push      = upd && (chg || hold_evt);
    rec.key       = key_index;
    rec.chg_valid = chg;
    rec.chg_press = raw_pressed;
    rec.hold      = hold_evt;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      raw_level       <= '0;
      debounced_level <= '0;
      hold_reported   <= '0;
      for (int i = 0; i < kmdh_pkg::KEY_COUNT; i++) begin
        raw_change_time[i] <= '0;
        press_time[i]      <= '0;
      end
    end else if (upd) begin
      raw_level[key_index]       <= raw_pressed;
      raw_change_time[key_index] <= change_time_next;
      debounced_level[key_index] <= deb_next;
      press_time[key_index]      <= press_time_next;
      hold_reported[key_index]   <= hold_rep_next || hold_evt;
    end
  end

  `KMDH_ASSERT_IMPLY(a_rec_nonempty, rec_push, rec.chg_valid || rec.hold)
  `KMDH_ASSERT_NEXT(a_hold_marks, rec_push && rec.hold, hold_reported[$past(key_index)])

endmodule

FILE: rtl/kmdh_queue.sv
// ----------------------------------------------------------------------------
// kmdh_queue
// short record queue between the classifying front and the event back end
// ----------------------------------------------------------------------------
`include "key_matrix_debounce_hold_events_assert.svh"

module kmdh_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 wr,
  input  kmdh_pkg::kmdh_rec_t  wr_rec,
  input  logic                 rd,
  output kmdh_pkg::kmdh_rec_t  rd_rec,
  output logic                 q_full,
  output logic                 q_empty
);

  kmdh_pkg::kmdh_rec_t             slots [kmdh_pkg::Q_DEPTH];
  logic [kmdh_pkg::Q_PTR_W-1:0]    wr_ptr;
  logic [kmdh_pkg::Q_PTR_W-1:0]    rd_ptr;
  logic [kmdh_pkg::Q_CNT_W-1:0]    count;
  logic                            do_wr;
  logic                            do_rd;

  always_comb begin
    q_full  = count == kmdh_pkg::Q_CNT_W'(kmdh_pkg::Q_DEPTH);
    q_empty = count == '0;
    do_wr   = wr && !q_full;
    do_rd   = rd && !q_empty;
    rd_rec  = slots[rd_ptr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= wr_rec;
    end
  end

  `KMDH_ASSERT_ALWAYS(a_count_bound, count <= kmdh_pkg::Q_CNT_W'(kmdh_pkg::Q_DEPTH))
  `KMDH_ASSERT_IMPLY(a_no_overflow, wr, !q_full)

endmodule

FILE: rtl/kmdh_back.sv
// ----------------------------------------------------------------------------
// kmdh_back
// expands queued records into result beats held in an output register
// ----------------------------------------------------------------------------
`include "key_matrix_debounce_hold_events_assert.svh"

module kmdh_back (
  input  logic                       clk,
  input  logic                       rst,
  input  kmdh_pkg::kmdh_rec_t        q_rec,
  input  logic                       q_empty,
  output logic                       q_pop,
  output logic [kmdh_pkg::KEY_W-1:0] event_key,
  output logic [1:0]                 event_kind,
  output logic                       last_event,
  output logic                       empty,
  input  logic                       pop
);

  logic                       out_valid;
  logic                       phase;       // 1 once the change beat of a two-beat record left
  logic                       phase_next;
  logic                       load;
  logic                       take;
  logic                       two_beats;
  kmdh_pkg::kmdh_kind_t       beat_kind;
  logic                       beat_last;

  always_comb begin
    load      = !out_valid || pop;
    take      = load && !q_empty;
    two_beats = q_rec.chg_valid && q_rec.hold;
    if (!phase && q_rec.chg_valid) begin
      beat_kind = q_rec.chg_press ? kmdh_pkg::KIND_PRESS : kmdh_pkg::KIND_RELEASE;
      beat_last = !q_rec.hold;
    end else begin
      beat_kind = kmdh_pkg::KIND_HOLD;
      beat_last = 1'b1;
    end
    q_pop      = take && !(!phase && two_beats);
    phase_next = take ? (!phase && two_beats) : phase;
    empty      = !out_valid;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      phase     <= 1'b0;
    end else begin
      phase <= phase_next;
      if (take) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      event_key  <= q_rec.key;
      event_kind <= beat_kind;
      last_event <= beat_last;
    end
  end

  `KMDH_ASSERT_IMPLY(a_phase_has_rec, phase, !q_empty && q_rec.hold)
  `KMDH_ASSERT_NEXT(a_first_beat_not_last, take && !phase && two_beats, !last_event)

endmodule

FILE: rtl/key_matrix_debounce_hold_events.sv
// ----------------------------------------------------------------------------
// key_matrix_debounce_hold_events
// keypad matrix debounce with press, release and hold events
// ----------------------------------------------------------------------------
// Takes one raw key sample per cycle (push/full) and returns press, release
// and hold events (empty/pop), at most two per sample, with last_event set on
// the final beat of each sample. The per-key state lives in flip-flops that
// reset clears at once, so the block takes samples right after reset. The
// front updates a key's state in the cycle it accepts the sample, so samples
// of the same key may follow back to back. The back end drives one beat per
// cycle from an output register; a four-record queue between the two absorbs
// bursts, and full rises only when that queue fills, which happens when
// samples produce events faster than one beat per cycle or pop is held low.
// Debounce and hold times are set through the APB port (debounce at 0x0, hold
// at 0x4, 16 bits each) by the user while the block is idle; it never checks.
// ----------------------------------------------------------------------------
module key_matrix_debounce_hold_events (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [2:0]                    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  input  logic                          push,
  output logic                          full,
  input  logic [kmdh_pkg::KEY_W-1:0]    key_index,
  input  logic                          raw_pressed,
  input  logic [kmdh_pkg::TIME_W-1:0]   now_ms,
  output logic                          empty,
  input  logic                          pop,
  output logic [kmdh_pkg::KEY_W-1:0]    event_key,
  output logic [1:0]                    event_kind,
  output logic                          last_event
);

  logic [kmdh_pkg::MS_W-1:0] debounce_ms;
  logic [kmdh_pkg::MS_W-1:0] hold_ms;
  logic                      cfg_wr;
  kmdh_pkg::kmdh_reg_t       reg_sel;
  logic                      accept;
  logic                      rec_push;
  kmdh_pkg::kmdh_rec_t       rec;
  kmdh_pkg::kmdh_rec_t       q_rec;
  logic                      q_pop;
  logic                      q_full;
  logic                      q_empty;

  always_comb begin
    pready  = 1'b1;
    cfg_wr  = psel && penable && pwrite && pready;
    reg_sel = kmdh_pkg::kmdh_reg_t'(paddr[2]);
    case (reg_sel)
      kmdh_pkg::REG_DEBOUNCE: prdata = {16'b0, debounce_ms};
      kmdh_pkg::REG_HOLD:     prdata = {16'b0, hold_ms};
      default:                prdata = '0;
    endcase
    full   = q_full;
    accept = push && !q_full;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_ms <= kmdh_pkg::DEBOUNCE_RESET;
      hold_ms     <= kmdh_pkg::HOLD_RESET;
    end else if (cfg_wr) begin
      case (reg_sel)
        kmdh_pkg::REG_DEBOUNCE: debounce_ms <= pwdata[15:0];
        kmdh_pkg::REG_HOLD:     hold_ms     <= pwdata[15:0];
        default: begin
        end
      endcase
    end
  end

  kmdh_front u_front (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .key_index   (key_index),
    .raw_pressed (raw_pressed),
    .now_ms      (now_ms),
    .debounce_ms (debounce_ms),
    .hold_ms     (hold_ms),
    .rec_push    (rec_push),
    .rec         (rec)
  );

  kmdh_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr      (rec_push),
    .wr_rec  (rec),
    .rd      (q_pop),
    .rd_rec  (q_rec),
    .q_full  (q_full),
    .q_empty (q_empty)
  );

  kmdh_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_rec      (q_rec),
    .q_empty    (q_empty),
    .q_pop      (q_pop),
    .event_key  (event_key),
    .event_kind (event_kind),
    .last_event (last_event),
    .empty      (empty),
    .pop        (pop)
  );

endmodule
